// ----- hw/rtl/lnwf_pkg.sv -----
// ----------------------------------------------------------------------------
// lnwf_pkg
// Shared types and constants of the display nibble write FIFO.
// ----------------------------------------------------------------------------
package lnwf_pkg;

   localparam int DEPTH_DEFAULT = 32;
   localparam int QUEUE_DEPTH   = 2;

   localparam logic [7:0] CMD_BIT   = 8'h80;
   localparam logic [6:0] RS_BIT    = 7'h10;
   localparam logic [6:0] EN_BIT    = 7'h40;
   localparam logic [3:0] NIB_MASK  = 4'hF;
   localparam logic [6:0] PORT_IDLE = 7'h00;

   localparam logic [2:0] LAST_BEAT = 3'd6;

   // Kind of work handed from front to back
   typedef enum logic {
      ENT_SINGLE,
      ENT_SEND
   } lnwf_kind_type;

   typedef struct packed {
      lnwf_kind_type kind;
      logic          accepted;
      logic [5:0]    fill;
      logic [7:0]    data_byte;
   } lnwf_entry_type;

endpackage

// ----- hw/rtl/lnwf_if.sv -----
// ----------------------------------------------------------------------------
// lnwf channel interfaces
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface lnwf_req_if;
   logic       valid;
   logic       ready;
   logic       mode;
   logic [7:0] data_byte;

   modport source (output valid, output mode, output data_byte, input ready);
   modport sink   (input valid, input mode, input data_byte, output ready);
endinterface

interface lnwf_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] port_value;
   logic       port_write;
   logic       push_accepted;
   logic [5:0] fill_level;
   logic       last;

   modport source (output valid, output port_value, output port_write,
                   output push_accepted, output fill_level, output last,
                   input ready);
   modport sink   (input valid, input port_value, input port_write,
                   input push_accepted, input fill_level, input last,
                   output ready);
endinterface

// ----- hw/rtl/lnwf_front.sv -----
// ----------------------------------------------------------------------------
// lnwf_front
// Accepts request beats, keeps the byte store and its indices, and turns each
// request into one work entry for the back end.
// ----------------------------------------------------------------------------
module lnwf_front #(
   parameter int DEPTH = lnwf_pkg::DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   lnwf_req_if.sink                 req,
   output logic                     ent_valid,
   output lnwf_pkg::lnwf_entry_type ent,
   input  logic                     ent_full
);
   import lnwf_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [7:0]    store [DEPTH];
   logic [AW-1:0] wr_idx_ff, wr_idx_in;
   logic [AW-1:0] rd_idx_ff, rd_idx_in;
   logic [CW-1:0] count_ff, count_in;
   logic          s1_valid_ff, s1_valid_in;
   lnwf_kind_type s1_kind_ff, s1_kind_in;
   logic          s1_acc_ff, s1_acc_in;
   logic [5:0]    s1_fill_ff, s1_fill_in;
   logic [7:0]    rd_data_ff;
   logic [CW+5:0] count_ext;

   logic accept;
   logic do_push;
   logic do_send;
   logic not_full;
   logic not_empty;

   assign not_full  = count_ff < CW'(DEPTH);
   assign not_empty = count_ff != '0;
   assign req.ready = !s1_valid_ff || !ent_full;
   assign accept    = req.valid && req.ready;
   assign do_push   = accept && !req.mode && not_full;
   assign do_send   = accept && req.mode && not_empty;

   assign ent_valid = s1_valid_ff;
   assign ent       = '{kind: s1_kind_ff, accepted: s1_acc_ff, fill: s1_fill_ff,
                        data_byte: rd_data_ff};

   function automatic logic [AW-1:0] next_idx(input logic [AW-1:0] idx);
      next_idx = (idx == AW'(DEPTH - 1)) ? '0 : idx + AW'(1);
   endfunction

   always_comb begin
      wr_idx_in   = wr_idx_ff;
      rd_idx_in   = rd_idx_ff;
      count_in    = count_ff;
      s1_kind_in  = s1_kind_ff;
      s1_acc_in   = s1_acc_ff;
      s1_fill_in  = s1_fill_ff;
      s1_valid_in = s1_valid_ff && ent_full;
      if (do_push) begin
         wr_idx_in = next_idx(wr_idx_ff);
         count_in  = count_ff + CW'(1);
      end
      if (do_send) begin
         rd_idx_in = next_idx(rd_idx_ff);
         count_in  = count_ff - CW'(1);
      end
      count_ext = {6'd0, count_in};
      if (accept) begin
         s1_valid_in = 1'b1;
         s1_kind_in  = do_send ? ENT_SEND : ENT_SINGLE;
         s1_acc_in   = do_push;
         s1_fill_in  = count_ext[5:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff   <= '0;
         rd_idx_ff   <= '0;
         count_ff    <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         wr_idx_ff   <= wr_idx_in;
         rd_idx_ff   <= rd_idx_in;
         count_ff    <= count_in;
         s1_valid_ff <= s1_valid_in;
      end
      s1_kind_ff <= s1_kind_in;
      s1_acc_ff  <= s1_acc_in;
      s1_fill_ff <= s1_fill_in;
   end

   // Byte store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (do_push) begin
         store[wr_idx_ff] <= req.data_byte;
      end
      if (do_send) begin
         rd_data_ff <= store[rd_idx_ff];
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("byte count above depth");

   a_empty_idx: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_idx_ff == rd_idx_ff))
      else $error("indices differ on empty store");

   a_hold_stage: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && ent_full) |-> !req.ready)
      else $error("request taken while stage blocked");

endmodule

// ----- hw/rtl/lnwf_queue.sv -----
// ----------------------------------------------------------------------------
// lnwf_queue
// Short entry queue between front and back end.
// ----------------------------------------------------------------------------
module lnwf_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  lnwf_pkg::lnwf_entry_type push_ent,
   output logic                     full,
   input  logic                     pop,
   output logic                     not_empty,
   output lnwf_pkg::lnwf_entry_type pop_ent
);
   import lnwf_pkg::*;

   localparam int QAW = $clog2(QUEUE_DEPTH);
   localparam int QCW = $clog2(QUEUE_DEPTH + 1);

   lnwf_entry_type slot_ff [QUEUE_DEPTH];
   logic [QAW-1:0] wr_ff;
   logic [QAW-1:0] rd_ff;
   logic [QCW-1:0] cnt_ff;
   logic           do_push;
   logic           do_pop;

   assign full      = cnt_ff == QCW'(QUEUE_DEPTH);
   assign not_empty = cnt_ff != '0;
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign pop_ent   = slot_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ff <= wr_ff + QAW'(1);
         end
         if (do_pop) begin
            rd_ff <= rd_ff + QAW'(1);
         end
         cnt_ff <= cnt_ff + QCW'(do_push) - QCW'(do_pop);
      end
      if (do_push) begin
         slot_ff[wr_ff] <= push_ent;
      end
   end

endmodule

// ----- hw/rtl/lnwf_back.sv -----
// ----------------------------------------------------------------------------
// lnwf_back
// Plays out work entries as response beats: one beat for a push or an idle
// pop, seven nibble-write beats for a sent byte.
// ----------------------------------------------------------------------------
module lnwf_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     ent_avail,
   input  lnwf_pkg::lnwf_entry_type ent,
   output logic                     ent_pop,
   lnwf_rsp_if.source               rsp
);
   import lnwf_pkg::*;

   logic           busy_ff;
   lnwf_entry_type cur_ff;
   logic [2:0]     beat_ff;
   logic           is_last;
   logic           done;
   logic [6:0]     sel;
   logic [6:0]     hi;
   logic [6:0]     lo;

   assign is_last = (cur_ff.kind == ENT_SINGLE) || (beat_ff == LAST_BEAT);
   assign done    = rsp.valid && rsp.ready && is_last;
   assign ent_pop = ent_avail && (!busy_ff || done);

   assign sel = ((cur_ff.data_byte & CMD_BIT) != 8'h00) ? PORT_IDLE : RS_BIT;
   assign hi  = sel | {3'b000, cur_ff.data_byte[7:4]};
   assign lo  = sel | {3'b000, cur_ff.data_byte[3:0] & NIB_MASK};

   always_comb begin
      rsp.port_value = PORT_IDLE;
      if (cur_ff.kind == ENT_SEND) begin
         unique case (beat_ff)
            3'd0, 3'd2: rsp.port_value = hi;
            3'd1:       rsp.port_value = hi | EN_BIT;
            3'd3, 3'd5: rsp.port_value = lo;
            3'd4:       rsp.port_value = lo | EN_BIT;
            default:    rsp.port_value = PORT_IDLE;
         endcase
      end
   end

   assign rsp.valid         = busy_ff;
   assign rsp.port_write    = cur_ff.kind == ENT_SEND;
   assign rsp.push_accepted = (cur_ff.kind == ENT_SINGLE) && cur_ff.accepted;
   assign rsp.fill_level    = cur_ff.fill;
   assign rsp.last          = is_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         beat_ff <= '0;
      end else if (ent_pop) begin
         busy_ff <= 1'b1;
         beat_ff <= '0;
      end else if (done) begin
         busy_ff <= 1'b0;
      end else if (rsp.valid && rsp.ready) begin
         // advance to the next nibble beat
         beat_ff <= beat_ff + 3'd1;
      end
      if (ent_pop) begin
         cur_ff <= ent;
      end
   end

   a_beat_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (beat_ff <= LAST_BEAT))
      else $error("beat counter beyond sequence");

   a_single_beat: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && (cur_ff.kind == ENT_SINGLE)) |-> (beat_ff == 3'd0))
      else $error("single entry past first beat");

   a_idle_value: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.port_write) |-> (rsp.port_value == PORT_IDLE))
      else $error("port value set without a write");

   a_hold_beat: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> (busy_ff && $stable(beat_ff)))
      else $error("beat moved while stalled");

endmodule

// ----- hw/rtl/lcd_nibble_write_fifo.sv -----
// ----------------------------------------------------------------------------
// lcd_nibble_write_fifo
// Byte FIFO feeding a character display port in 4-bit mode.
// ----------------------------------------------------------------------------
// A push request stores its byte (or drops it when DEPTH bytes are held) and
// yields one response beat; a pop yields one idle beat on an empty store, or
// seven nibble-write beats carrying the oldest byte. The front end takes one
// request per cycle while its output stage and the two-entry work queue have
// room, so pushes run back to back; the back end plays out one response beat
// per cycle when rsp is ready, so a sending pop holds the response channel
// for its seven beats and sets the sustained rate of pops. A request reaches
// rsp through the front output stage (store read), a queue slot and the back
// end's entry register. The byte store needs no clearing after reset.
// ----------------------------------------------------------------------------
module lcd_nibble_write_fifo #(
   parameter int DEPTH = lnwf_pkg::DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   lnwf_req_if.sink    req_ch,
   lnwf_rsp_if.source  rsp_ch
);
   import lnwf_pkg::*;

   logic           front_valid;
   lnwf_entry_type front_ent;
   logic           q_full;
   logic           q_avail;
   logic           q_pop;
   lnwf_entry_type q_ent;

   lnwf_front #(
      .DEPTH(DEPTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .ent_valid (front_valid),
      .ent       (front_ent),
      .ent_full  (q_full)
   );

   lnwf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_valid),
      .push_ent  (front_ent),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_avail),
      .pop_ent   (q_ent)
   );

   lnwf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .ent_avail (q_avail),
      .ent       (q_ent),
      .ent_pop   (q_pop),
      .rsp       (rsp_ch)
   );

endmodule
